>>> sv/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros for the checker file
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on the rising edge, off during reset
`define CHK_IMPLY(name, clock, reset_n, ante, cons, msg) \
    name: assert property (@(posedge clock) disable iff (!reset_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on the rising edge, off during reset
`define CHK_NEXT(name, clock, reset_n, ante, cons, msg) \
    name: assert property (@(posedge clock) disable iff (!reset_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/bsw_pkg.sv
// ---------------------------------------------------------------------------
// bsw_pkg
// types, constants and header layout for the bmp stream writer
// ---------------------------------------------------------------------------
package bsw_pkg;

    localparam int MAX_DIM_DEF     = 4096;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int DIM_W     = 13;
    localparam int CFG_IDX_W = 1;
    localparam int HDR_IDX_W = 6;
    localparam int HDR_WORDS = 13;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

    localparam logic [HDR_IDX_W-1:0] HDR_IDX_B     = 6'd0;
    localparam logic [HDR_IDX_W-1:0] HDR_IDX_M     = 6'd1;
    localparam logic [HDR_IDX_W-1:0] HDR_IDX_WORDS = 6'd2;
    localparam logic [HDR_IDX_W-1:0] HDR_IDX_LAST  = 6'd53;

    localparam logic [7:0]  CHAR_B       = 8'h42;
    localparam logic [7:0]  CHAR_M       = 8'h4D;
    localparam logic [31:0] DATA_OFFSET  = 32'd54;
    localparam logic [31:0] INFO_SIZE    = 32'd40;
    localparam logic [15:0] PLANES       = 16'd1;
    localparam logic [15:0] BIT_DEPTH    = 16'd24;
    localparam logic [31:0] RESOLUTION   = 32'd2835;

    typedef enum logic [2:0] {
        ST_NEXT,
        ST_HDR,
        ST_BLUE,
        ST_GREEN,
        ST_RED,
        ST_PAD
    } bsw_state_t;

    // one classified pixel, handed from front to back
    typedef struct packed {
        logic [7:0]       blue;
        logic [7:0]       green;
        logic [7:0]       red;
        logic             hdr;
        logic [1:0]       pad;
        logic             last;
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic [31:0]      img_size;
    } bsw_job_t;

    // byte idx of the 54-byte header; after "BM" it is 13 little-endian words
    function automatic logic [7:0] hdr_byte(
        input logic [HDR_IDX_W-1:0] idx,
        input logic [DIM_W-1:0]     w,
        input logic [DIM_W-1:0]     h,
        input logic [31:0]          img
    );
        logic [HDR_IDX_W-1:0] m;
        logic [31:0]          words [HDR_WORDS];
        logic [31:0]          word;
        logic [7:0]           res;
        m     = idx - HDR_IDX_WORDS;
        words = '{img + DATA_OFFSET, 32'd0, DATA_OFFSET, INFO_SIZE,
                  {{(32-DIM_W){1'b0}}, w}, {{(32-DIM_W){1'b0}}, h},
                  {BIT_DEPTH, PLANES}, 32'd0, img, RESOLUTION, RESOLUTION,
                  32'd0, 32'd0};
        word  = (m[HDR_IDX_W-1:2] < 4'(HDR_WORDS)) ? words[m[HDR_IDX_W-1:2]] : 32'd0;
        res   = 8'(word >> {m[1:0], 3'b000});
        if (idx == HDR_IDX_B)
        begin
            res = CHAR_B;
        end
        else if (idx == HDR_IDX_M)
        begin
            res = CHAR_M;
        end
        return res;
    endfunction

endpackage

>>> sv/bsw_front.sv
// ---------------------------------------------------------------------------
// bsw_front
// config registers, pixel acceptance, row and frame bookkeeping
// ---------------------------------------------------------------------------
module bsw_front
    import bsw_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           red,
    input  logic [7:0]           green,
    input  logic [7:0]           blue,
    input  logic                 q_full,
    output logic                 push,
    output bsw_job_t             push_job
);

    logic [DIM_W-1:0]   width_reg;
    logic [DIM_W-1:0]   height_reg;
    logic               header_sent_reg;
    logic               header_sent_next;
    logic [DIM_W-1:0]   col_reg;
    logic [DIM_W-1:0]   col_next;
    logic [DIM_W-1:0]   row_reg;
    logic [DIM_W-1:0]   row_next;

    logic [DIM_W-1:0]   w_eff;
    logic [DIM_W-1:0]   h_eff;
    logic [DIM_W+1:0]   stride;
    logic [2*DIM_W+1:0] img_prod;
    logic               col_end;
    logic               row_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_W'(1);
            height_reg <= DIM_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // zero reads as one, oversize reads as the limit
    always_comb
    begin
        if (width_reg == '0)
            w_eff = DIM_W'(1);
        else if (32'(width_reg) > 32'(MAX_DIM))
            w_eff = DIM_W'(MAX_DIM);
        else
            w_eff = width_reg;

        if (height_reg == '0)
            h_eff = DIM_W'(1);
        else if (32'(height_reg) > 32'(MAX_DIM))
            h_eff = DIM_W'(MAX_DIM);
        else
            h_eff = height_reg;
    end

    // 3w plus pad; pad to a multiple of four is just w mod 4
    assign stride   = {2'b00, w_eff} + {1'b0, w_eff, 1'b0} + (DIM_W+2)'(w_eff[1:0]);
    assign img_prod = (2*DIM_W+2)'(stride) * (2*DIM_W+2)'(h_eff);

    assign col_end = ({1'b0, col_reg} + (DIM_W+1)'(1)) >= {1'b0, w_eff};
    assign row_end = ({1'b0, row_reg} + (DIM_W+1)'(1)) >= {1'b0, h_eff};

    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

    always_comb
    begin
        push_job.blue     = blue;
        push_job.green    = green;
        push_job.red      = red;
        push_job.hdr      = !header_sent_reg;
        push_job.pad      = col_end ? w_eff[1:0] : 2'd0;
        push_job.last     = col_end && row_end;
        push_job.width    = w_eff;
        push_job.height   = h_eff;
        push_job.img_size = 32'(img_prod);
    end

    always_comb
    begin
        header_sent_next = 1'b1;
        col_next         = col_reg + DIM_W'(1);
        row_next         = row_reg;
        if (col_end)
        begin
            col_next = '0;
            if (row_end)
            begin
                row_next         = '0;
                header_sent_next = 1'b0;
            end
            else
            begin
                row_next = row_reg + DIM_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_sent_reg <= 1'b0;
            col_reg         <= '0;
            row_reg         <= '0;
        end
        else if (push)
        begin
            header_sent_reg <= header_sent_next;
            col_reg         <= col_next;
            row_reg         <= row_next;
        end
    end

endmodule

>>> sv/bsw_queue.sv
// ---------------------------------------------------------------------------
// bsw_queue
// short fifo of classified pixels between front and back
// ---------------------------------------------------------------------------
module bsw_queue
    import bsw_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  bsw_job_t push_job,
    input  logic     pop,
    output logic     full,
    output logic     valid,
    output bsw_job_t head
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    bsw_job_t         entries [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full  = count_reg == CNT_W'(DEPTH);
    assign valid = count_reg != '0;
    assign head  = entries[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entries[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
    end

endmodule

>>> sv/bsw_back.sv
// ---------------------------------------------------------------------------
// bsw_back
// byte sequencer: header, blue, green, red, row padding into the output register
// ---------------------------------------------------------------------------
module bsw_back
    import bsw_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     q_valid,
    input  bsw_job_t q_head,
    output logic     pop,
    output logic     out_valid,
    input  logic     out_stall,
    output logic [7:0] out_byte,
    output logic     frame_last
);

    bsw_state_t           state_reg;
    bsw_state_t           state_next;
    logic [HDR_IDX_W-1:0] hdr_idx_reg;
    logic [HDR_IDX_W-1:0] hdr_idx_next;
    logic [1:0]           pad_left_reg;
    logic [1:0]           pad_left_next;

    logic                 out_valid_reg;
    logic [7:0]           out_byte_reg;
    logic                 frame_last_reg;

    logic                 adv;
    logic                 emit;
    logic                 done;
    logic [7:0]           byte_val;
    logic                 last_val;

    // output register free or being drained this cycle
    assign adv = !out_valid_reg || !out_stall;

    // outputs of the sequencer
    always_comb
    begin
        emit     = 1'b1;
        done     = 1'b0;
        byte_val = 8'd0;
        case (state_reg)
            ST_NEXT:
            begin
                emit     = q_valid;
                byte_val = q_head.hdr ? CHAR_B : q_head.blue;
            end
            ST_HDR:
            begin
                byte_val = hdr_byte(hdr_idx_reg, q_head.width, q_head.height,
                                    q_head.img_size);
            end
            ST_BLUE:  byte_val = q_head.blue;
            ST_GREEN: byte_val = q_head.green;
            ST_RED:
            begin
                byte_val = q_head.red;
                done     = q_head.pad == 2'd0;
            end
            ST_PAD:
            begin
                done = pad_left_reg == 2'd1;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
        last_val = done && q_head.last;
        pop      = adv && emit && done;
    end

    // next state
    always_comb
    begin
        state_next    = state_reg;
        hdr_idx_next  = hdr_idx_reg;
        pad_left_next = pad_left_reg;
        if (adv && emit)
        begin
            case (state_reg)
                ST_NEXT:
                begin
                    if (q_head.hdr)
                    begin
                        state_next   = ST_HDR;
                        hdr_idx_next = HDR_IDX_M;
                    end
                    else
                    begin
                        state_next = ST_GREEN;
                    end
                end
                ST_HDR:
                begin
                    hdr_idx_next = hdr_idx_reg + HDR_IDX_W'(1);
                    if (hdr_idx_reg == HDR_IDX_LAST)
                        state_next = ST_BLUE;
                end
                ST_BLUE:  state_next = ST_GREEN;
                ST_GREEN: state_next = ST_RED;
                ST_RED:
                begin
                    if (done)
                    begin
                        state_next = ST_NEXT;
                    end
                    else
                    begin
                        state_next    = ST_PAD;
                        pad_left_next = q_head.pad;
                    end
                end
                ST_PAD:
                begin
                    pad_left_next = pad_left_reg - 2'd1;
                    if (done)
                        state_next = ST_NEXT;
                end
                default: state_next = ST_NEXT;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_NEXT;
            hdr_idx_reg   <= '0;
            pad_left_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            hdr_idx_reg  <= hdr_idx_next;
            pad_left_reg <= pad_left_next;
            if (adv)
                out_valid_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_byte_reg   <= byte_val;
            frame_last_reg <= last_val;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign frame_last = frame_last_reg;

endmodule

>>> sv/bmp_24bit_stream_writer.sv
// ---------------------------------------------------------------------------
// bmp_24bit_stream_writer
// rgba pixels in raster order to a 24-bit bmp byte stream
//
//   channel   dir   handshake            payload
//   in        in    in_valid/in_stall    red, green, blue, alpha
//   out       out   out_valid/out_stall  out_byte, frame_last
//   cfg       in    cfg_we               cfg_index, cfg_data
//
// a pixel is three bytes on the byte-wide output register, plus up to 3 pad
// bytes at a row end and 54 header bytes on the first pixel of a frame
// a short queue lets pixels enter every cycle until it holds QUEUE_DEPTH
// the first pixel taken reaches the port through the queue, then the output register
// rst_n clears the counters, the queue and the sequencer; dims reset to 1
// out_stall holds the current beat; in_stall rises only when the queue is full
// ---------------------------------------------------------------------------
module bmp_24bit_stream_writer
    import bsw_pkg::*;
#(
    parameter int MAX_DIM     = MAX_DIM_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           red,
    input  logic [7:0]           green,
    input  logic [7:0]           blue,
    input  logic [7:0]           alpha,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [7:0]           out_byte,
    output logic                 frame_last
);

    logic     push;
    bsw_job_t push_job;
    logic     pop;
    logic     q_full;
    logic     q_valid;
    bsw_job_t q_head;

    // alpha is taken with the beat and dropped

    bsw_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .q_full    (q_full),
        .push      (push),
        .push_job  (push_job)
    );

    bsw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .full     (q_full),
        .valid    (q_valid),
        .head     (q_head)
    );

    bsw_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_head     (q_head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .frame_last (frame_last)
    );

endmodule

>>> sv/bsw_checker.sv
// ---------------------------------------------------------------------------
// bsw_checker
// port-level checks on the bmp stream writer, bound to the top level
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bsw_checker
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [7:0] out_byte,
    input  logic       frame_last
);

    // a held beat keeps its payload
    `CHK_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_byte) && $stable(frame_last), "output beat changed while stalled")

    // back-pressure only when pixels are already queued, so output has work
    `CHK_IMPLY(a_stall_busy, clk, rst_n, in_stall, out_valid, "input stalled with no output pending")

    // a beat right after the frame end opens the next header
    `CHK_NEXT(a_frame_restart, clk, rst_n, out_valid && !out_stall && frame_last, !out_valid || out_byte == 8'h42, "next frame does not start with header")

endmodule

bind bmp_24bit_stream_writer bsw_checker u_bsw_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .frame_last (frame_last)
);
